// ----- hw/rtl/pgf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared types and codes of the pcm gain, fade and format block.
// ----------------------------------------------------------------------------
package pgf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int MODE_W   = 2;
    localparam int REQ_W    = 2;

    // gain fraction bits, Q4.12
    localparam int GAIN_FRAC = 12;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 2'd2;

    // output encodings
    localparam logic [MODE_W-1:0] MODE_SIGNED16 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DAC8     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DAC16    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

    // register indexes of the configuration channel
    localparam logic CFG_ENC_MODE    = 1'b0;
    localparam logic CFG_VOLUME_GAIN = 1'b1;

    // one sample pair and its gain, waiting for the back end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [GAIN_W-1:0]          gain;
        logic [MODE_W-1:0]          mode;
    } pgf_item_t;

endpackage

// ----- hw/rtl/pgf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_front
// Accepts request beats, tracks run state and the gain ramp, queues pairs.
// ----------------------------------------------------------------------------
module pgf_front #(
    parameter int DELAY_BLOCKS = 16,
    parameter int FADE_BLOCKS  = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pgf_pkg::REQ_W-1:0]           in_req,
    input  logic signed [pgf_pkg::SAMPLE_W-1:0] in_left,
    input  logic signed [pgf_pkg::SAMPLE_W-1:0] in_right,
    input  logic                                in_block_start,
    input  logic                                in_mono,
    input  logic [pgf_pkg::MODE_W-1:0]          enc_mode,
    input  logic [pgf_pkg::GAIN_W-1:0]          volume_gain,
    output logic                                push_valid,
    input  logic                                push_ready,
    output pgf_pkg::pgf_item_t                  push_item
);

    localparam int FADE_W  = $clog2(FADE_BLOCKS + 1);
    localparam int PROD_W  = pgf_pkg::GAIN_W + FADE_W;
    // rounded-up reciprocal of the fade length, exact for any product below 2^PROD_W
    localparam int DIV_W   = $clog2(FADE_BLOCKS);
    localparam int SHIFT   = PROD_W + DIV_W;
    localparam int RECIP_W = PROD_W + 1;
    localparam int QPROD_W = PROD_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(FADE_BLOCKS - 1)) / 64'(FADE_BLOCKS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_DIV  = 3'b100
    } front_state_t;

    front_state_t                      state_reg, state_next;
    logic                              running_reg, running_next;
    logic [7:0]                        delay_count_reg, delay_count_next;
    logic [FADE_W-1:0]                 fade_count_reg, fade_count_next;
    logic [pgf_pkg::GAIN_W-1:0]        gain_reg, gain_next;
    logic                              pend_reg, pend_next;

    logic [FADE_W-1:0]                 k_reg, k_next;
    logic [PROD_W-1:0]                 num_reg, num_next;
    logic signed [pgf_pkg::SAMPLE_W-1:0] hold_left_reg, hold_left_next;
    logic signed [pgf_pkg::SAMPLE_W-1:0] hold_right_reg, hold_right_next;

    logic                              accept;
    logic                              out_on;
    logic [PROD_W-1:0]                 prod;
    logic [QPROD_W-1:0]                qprod;
    logic signed [pgf_pkg::SAMPLE_W-1:0] right_sel;

    assign in_ready  = (state_reg == F_IDLE) && push_ready;
    assign accept    = in_valid && in_ready;
    assign out_on    = running_reg && (enc_mode != pgf_pkg::MODE_NONE);
    assign prod      = PROD_W'(volume_gain) * PROD_W'(k_reg);
    // divide by the fade length as a multiply by its reciprocal
    assign qprod     = QPROD_W'(num_reg) * QPROD_W'(RECIP);
    assign right_sel = in_mono ? in_left : in_right;

    always_comb
    begin
        state_next       = state_reg;
        running_next     = running_reg;
        delay_count_next = delay_count_reg;
        fade_count_next  = fade_count_reg;
        gain_next        = gain_reg;
        pend_next        = pend_reg;
        k_next           = k_reg;
        num_next         = num_reg;
        hold_left_next   = hold_left_reg;
        hold_right_next  = hold_right_reg;
        push_valid       = 1'b0;
        push_item.left   = in_left;
        push_item.right  = right_sel;
        push_item.mode   = enc_mode;

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (in_req)
                        pgf_pkg::REQ_START:
                        begin
                            if (!running_reg)
                            begin
                                delay_count_next = '0;
                                fade_count_next  = '0;
                                running_next     = 1'b1;
                            end
                        end
                        pgf_pkg::REQ_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        pgf_pkg::REQ_SAMPLE:
                        begin
                            push_valid = out_on;
                            if (in_block_start)
                            begin
                                if ({1'b0, delay_count_reg} < 9'(DELAY_BLOCKS))
                                begin
                                    gain_next        = '0;
                                    delay_count_next = delay_count_reg + 8'd1;
                                end
                                else if (fade_count_reg < FADE_W'(FADE_BLOCKS))
                                begin
                                    // ramp step goes through the divider
                                    push_valid      = 1'b0;
                                    k_next          = fade_count_reg;
                                    fade_count_next = fade_count_reg + FADE_W'(1);
                                    pend_next       = out_on;
                                    hold_left_next  = in_left;
                                    hold_right_next = right_sel;
                                    state_next      = F_MUL;
                                end
                                else
                                begin
                                    gain_next = volume_gain;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_MUL:
            begin
                num_next   = prod;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                gain_next       = qprod[SHIFT+pgf_pkg::GAIN_W-1:SHIFT];
                push_valid      = pend_reg;
                push_item.left  = hold_left_reg;
                push_item.right = hold_right_reg;
                state_next      = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        push_item.gain = gain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            running_reg     <= 1'b0;
            delay_count_reg <= '0;
            fade_count_reg  <= '0;
            gain_reg        <= '0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            running_reg     <= running_next;
            delay_count_reg <= delay_count_next;
            fade_count_reg  <= fade_count_next;
            gain_reg        <= gain_next;
            pend_reg        <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        num_reg        <= num_next;
        hold_left_reg  <= hold_left_next;
        hold_right_reg <= hold_right_next;
    end

endmodule

// ----- hw/rtl/pgf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_queue
// Two-entry queue between the front end and the scaling back end.
// ----------------------------------------------------------------------------
module pgf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pgf_pkg::pgf_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pgf_pkg::pgf_item_t out_item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    pgf_pkg::pgf_item_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]             count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/pgf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgf_back
// Scales a queued pair by its gain and encodes both words for output.
// ----------------------------------------------------------------------------
module pgf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pgf_pkg::pgf_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pgf_pkg::SAMPLE_W-1:0]  out_left,
    output logic [pgf_pkg::SAMPLE_W-1:0]  out_right
);

    localparam int MAG_W  = pgf_pkg::SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + pgf_pkg::GAIN_W;
    localparam int SH_W   = PROD_W - pgf_pkg::GAIN_FRAC;

    logic                            mul_valid_reg, mul_valid_next;
    logic [PROD_W-1:0]               lprod_reg, rprod_reg;
    logic                            lneg_reg, rneg_reg;
    logic [pgf_pkg::MODE_W-1:0]      mode_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [pgf_pkg::SAMPLE_W-1:0]    out_left_reg, out_right_reg;

    logic                            adv;
    logic                            load;
    logic [MAG_W-1:0]                lmag, rmag;

    function automatic logic [MAG_W-1:0] abs_mag(input logic signed [pgf_pkg::SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] x;
        x = {s[pgf_pkg::SAMPLE_W-1], s};
        return s[pgf_pkg::SAMPLE_W-1] ? (~x + MAG_W'(1)) : x;
    endfunction

    // truncate toward zero, saturate to 16 bits, then encode
    function automatic logic [pgf_pkg::SAMPLE_W-1:0] encode(
        input logic [PROD_W-1:0]          prod,
        input logic                       neg,
        input logic [pgf_pkg::MODE_W-1:0] mode
    );
        logic [SH_W-1:0]                  mag;
        logic [pgf_pkg::SAMPLE_W-1:0]     sat;
        logic [pgf_pkg::SAMPLE_W-1:0]     v;
        logic [pgf_pkg::SAMPLE_W-1:0]     word;
        mag = prod[PROD_W-1:pgf_pkg::GAIN_FRAC];
        if (neg)
        begin
            sat = (mag > SH_W'(32768)) ? 16'h8000 : mag[pgf_pkg::SAMPLE_W-1:0];
            v   = ~sat + 16'd1;
        end
        else
        begin
            sat = (mag > SH_W'(32767)) ? 16'h7FFF : mag[pgf_pkg::SAMPLE_W-1:0];
            v   = sat;
        end
        case (mode)
            pgf_pkg::MODE_DAC8:  word = {v[15:8] ^ 8'h80, 8'h00};
            pgf_pkg::MODE_DAC16: word = v ^ 16'h8000;
            default:             word = v;
        endcase
        return word;
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign load     = !mul_valid_reg || adv;
    assign in_ready = load;
    assign lmag     = abs_mag(in_item.left);
    assign rmag     = abs_mag(in_item.right);

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    always_comb
    begin
        mul_valid_next = load ? in_valid : mul_valid_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = mul_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            lprod_reg <= PROD_W'(lmag) * PROD_W'(in_item.gain);
            rprod_reg <= PROD_W'(rmag) * PROD_W'(in_item.gain);
            lneg_reg  <= in_item.left[pgf_pkg::SAMPLE_W-1];
            rneg_reg  <= in_item.right[pgf_pkg::SAMPLE_W-1];
            mode_reg  <= in_item.mode;
        end
        if (adv && mul_valid_reg)
        begin
            out_left_reg  <= encode(lprod_reg, lneg_reg, mode_reg);
            out_right_reg <= encode(rprod_reg, rneg_reg, mode_reg);
        end
    end

endmodule

// ----- hw/rtl/pcm_gain_fade_formatter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_gain_fade_formatter
// Stereo pcm gain with start delay, linear fade-in and output word encoding.
// ----------------------------------------------------------------------------
// A request beat is a sample pair, a start or a stop (s_tuser). A start
// while stopped arms the output and restarts the ramp: after DELAY_BLOCKS
// blocks at gain zero, the gain steps linearly to volume_gain over
// FADE_BLOCKS blocks, then holds. The gain moves only on a pair marked as
// the first of a block. Each pair is scaled by the Q4.12 gain, truncated
// toward zero and sent as signed 16-bit, 8-bit dac (upper byte, offset
// binary) or 16-bit dac. Stopped or in the no-output mode, pairs give no
// output beat. Requests are taken only in the idle state; a block-start
// pair inside the fade then passes a state for the volume times step
// multiply and one for the multiply by the reciprocal of the fade length.
// The back end scales one pair per cycle unless the output stalls, through
// a multiply and an output register; a two-entry queue decouples the ends.
// ----------------------------------------------------------------------------
module pcm_gain_fade_formatter #(
    parameter int DELAY_BLOCKS = 16,
    parameter int FADE_BLOCKS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // left_sample, right_sample, block_start, mono, zero pad
    input  logic [1:0]  s_tuser,   // req_type

    // formatted output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_word, right_word

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [pgf_pkg::MODE_W-1:0] enc_mode_reg, enc_mode_next;
    logic [pgf_pkg::GAIN_W-1:0] volume_gain_reg, volume_gain_next;

    logic                       q_in_valid;
    logic                       q_in_ready;
    pgf_pkg::pgf_item_t         q_in_item;
    logic                       q_out_valid;
    logic                       q_out_ready;
    pgf_pkg::pgf_item_t         q_out_item;

    logic [15:0]                left_word;
    logic [15:0]                right_word;

    // registers are always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        enc_mode_next    = enc_mode_reg;
        volume_gain_next = volume_gain_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pgf_pkg::CFG_ENC_MODE:    enc_mode_next    = cfg_data[pgf_pkg::MODE_W-1:0];
                pgf_pkg::CFG_VOLUME_GAIN: volume_gain_next = cfg_data;
                default:                  enc_mode_next    = enc_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_mode_reg    <= pgf_pkg::MODE_SIGNED16;
            volume_gain_reg <= 16'd4096;
        end
        else
        begin
            enc_mode_reg    <= enc_mode_next;
            volume_gain_reg <= volume_gain_next;
        end
    end

    // front end: request decode, run state, gain ramp
    pgf_front #(
        .DELAY_BLOCKS (DELAY_BLOCKS),
        .FADE_BLOCKS  (FADE_BLOCKS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_req         (s_tuser),
        .in_left        (s_tdata[15:0]),
        .in_right       (s_tdata[31:16]),
        .in_block_start (s_tdata[32]),
        .in_mono        (s_tdata[33]),
        .enc_mode       (enc_mode_reg),
        .volume_gain    (volume_gain_reg),
        .push_valid     (q_in_valid),
        .push_ready     (q_in_ready),
        .push_item      (q_in_item)
    );

    pgf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    // back end: multiply, saturate, encode, output register
    pgf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_out_valid),
        .in_ready  (q_out_ready),
        .in_item   (q_out_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_left  (left_word),
        .out_right (right_word)
    );

    assign m_tdata = {right_word, left_word};

endmodule

// ----- dv/pcm_gain_fade_formatter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_gain_fade_formatter_tb
// Self-checking bench for the pcm gain, fade and format block.
// ----------------------------------------------------------------------------
// Request beats come from a queue that the stimulus process fills phase by
// phase. A clocked driver presents them with random gaps, a clocked monitor
// tracks the start delay, fade ramp and gain on every accepted request and
// queues the formatted words it expects, then checks each output beat
// against the oldest of them. The output side stalls at random. Between
// phases the bench drains, lets the block settle and rewrites the mode and
// volume registers.
// ----------------------------------------------------------------------------
module pcm_gain_fade_formatter_tb;

    localparam int DELAY_BLOCKS  = 16;
    localparam int FADE_BLOCKS   = 64;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 130;

    typedef struct {
        logic [pgf_pkg::REQ_W-1:0]           kind;
        logic signed [pgf_pkg::SAMPLE_W-1:0] left;
        logic signed [pgf_pkg::SAMPLE_W-1:0] right;
        logic                                block_start;
        logic                                mono;
    } pcm_req_t;

    typedef struct {
        logic [15:0] left_word;
        logic [15:0] right_word;
    } pcm_words_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // left_sample, right_sample, block_start, mono, zero pad
    logic [1:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // left_word, right_word
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    pcm_gain_fade_formatter #(
        .DELAY_BLOCKS (DELAY_BLOCKS),
        .FADE_BLOCKS  (FADE_BLOCKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus and expectation stores
    pcm_req_t   pending_reqs[$];
    pcm_words_t words_due[$];
    pcm_req_t   cur_req;
    int         req_sent  = 0;
    int         req_taken = 0;
    int         req_gap   = 0;
    int         out_cnt   = 0;
    int         out_seen  = 0;
    int         rx_hold   = 0;
    int         fails     = 0;
    bit         calm      = 1'b0;   // no idling on either side while set

    // predictor state, mirrors the block's registers
    logic [pgf_pkg::MODE_W-1:0] mode_now;
    logic [pgf_pkg::GAIN_W-1:0] vol_now;
    logic [pgf_pkg::GAIN_W-1:0] gain_now;
    int                         dly_done;
    int                         fade_done;
    bit                         run_on;

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // sample times Q4.12 gain, truncated toward zero
    function automatic int scaled(input logic signed [15:0] s, input logic [15:0] g);
        longint mag;
        longint prod;
        mag  = (s < 0) ? -longint'(s) : longint'(s);
        prod = (mag * longint'(g)) >>> pgf_pkg::GAIN_FRAC;
        return int'((s < 0) ? -prod : prod);
    endfunction

    function automatic logic [15:0] encode_word(input int p,
                                                input logic [pgf_pkg::MODE_W-1:0] mode);
        logic signed [31:0] v;
        logic [31:0]        off;
        v   = (p < -32768) ? -32768 : ((p > 32767) ? 32767 : p);
        off = v + 32768;
        case (mode)
            pgf_pkg::MODE_SIGNED16: return v[15:0];
            pgf_pkg::MODE_DAC8:     return {off[15:8], 8'h00};
            default:                return off[15:0];
        endcase
    endfunction

    // gain moves one step per block: zero through the delay, then the ramp
    function automatic void step_gain();
        if (dly_done < DELAY_BLOCKS)
        begin
            gain_now = '0;
            dly_done++;
        end
        else if (fade_done < FADE_BLOCKS)
        begin
            gain_now = 16'((longint'(vol_now) * fade_done) / FADE_BLOCKS);
            fade_done++;
        end
        else
            gain_now = vol_now;
    endfunction

    function automatic void apply_request(input pcm_req_t r);
        pcm_words_t w;
        logic signed [15:0] rs;
        case (r.kind)
            pgf_pkg::REQ_START:
                if (!run_on)
                begin
                    dly_done  = 0;
                    fade_done = 0;
                    run_on    = 1'b1;
                end
            pgf_pkg::REQ_STOP:
                run_on = 1'b0;
            pgf_pkg::REQ_SAMPLE:
            begin
                if (r.block_start)
                    step_gain();
                if (run_on && mode_now != pgf_pkg::MODE_NONE)
                begin
                    rs           = r.mono ? r.left : r.right;
                    w.left_word  = encode_word(scaled(r.left, gain_now), mode_now);
                    w.right_word = encode_word(scaled(rs, gain_now), mode_now);
                    words_due.push_back(w);
                end
            end
            default: ;   // unused request kind is dropped
        endcase
    endfunction

    // request driver: one beat in flight, random gap after each acceptance
    always @(negedge clk)
    begin
        if (rst_n && req_sent == req_taken)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                s_tdata <= {6'b0, cur_req.mono, cur_req.block_start,
                            cur_req.right, cur_req.left};
                s_tuser  <= cur_req.kind;
                s_tvalid <= 1'b1;
                req_sent++;
                req_gap = idle_draw();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side backpressure, redrawn after every output beat
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_seen != out_cnt)
            begin
                out_seen = out_cnt;
                rx_hold  = idle_draw();
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: register writes, accepted requests and output beats
    always @(posedge clk)
    begin
        pcm_words_t w;
        if (!rst_n)
        begin
            mode_now  = pgf_pkg::MODE_SIGNED16;
            vol_now   = 16'd4096;
            gain_now  = '0;
            dly_done  = 0;
            fade_done = 0;
            run_on    = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pgf_pkg::CFG_ENC_MODE:    mode_now = cfg_data[pgf_pkg::MODE_W-1:0];
                    pgf_pkg::CFG_VOLUME_GAIN: vol_now  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(cur_req);
                req_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                out_cnt++;
                if (words_due.size() == 0)
                begin
                    $error("output beat %h with nothing expected", m_tdata);
                    fails++;
                end
                else
                begin
                    w = words_due.pop_front();
                    if (m_tdata[15:0] !== w.left_word)
                    begin
                        $error("left_word expected %h actual %h", w.left_word, m_tdata[15:0]);
                        fails++;
                    end
                    if (m_tdata[31:16] !== w.right_word)
                    begin
                        $error("right_word expected %h actual %h",
                               w.right_word, m_tdata[31:16]);
                        fails++;
                    end
                end
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_req(input logic [pgf_pkg::REQ_W-1:0] kind);
        pcm_req_t r;
        r.kind        = kind;
        r.left        = 16'($urandom);
        r.right       = 16'($urandom);
        r.block_start = 1'($urandom);
        r.mono        = 1'($urandom);
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                                       input logic bs, input logic mono);
        pcm_req_t q;
        q.kind        = pgf_pkg::REQ_SAMPLE;
        q.left        = l;
        q.right       = r;
        q.block_start = bs;
        q.mono        = mono;
        pending_reqs.push_back(q);
    endfunction

    // a start, a run of pairs with random content, then often a stop;
    // now and then a stray request lands in between
    function automatic int queue_session();
        int n;
        int bs_odds;
        n       = $urandom_range(10, 200);
        bs_odds = ($urandom_range(0, 3) == 0) ? 8 : 2;
        queue_req(pgf_pkg::REQ_START);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                queue_req(pgf_pkg::REQ_W'($urandom_range(0, 3)));
            else
                queue_pair(pick_sample(), pick_sample(),
                           $urandom_range(1, bs_odds) == 1, $urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 2) != 0)
            queue_req(pgf_pkg::REQ_STOP);
        return n + 2;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || req_sent != req_taken || words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [pgf_pkg::MODE_W-1:0] modes[8];
        logic [15:0]                vols[8];
        int                         sent;

        modes = '{pgf_pkg::MODE_DAC8, pgf_pkg::MODE_DAC16, pgf_pkg::MODE_NONE,
                  pgf_pkg::MODE_SIGNED16, pgf_pkg::MODE_DAC16, pgf_pkg::MODE_DAC8,
                  pgf_pkg::MODE_SIGNED16, pgf_pkg::MODE_DAC16};
        vols  = '{16'hFFFF, 16'hFFFF, 16'($urandom), 16'h0000,
                  16'($urandom), 16'($urandom), 16'hFFFF, 16'd4096};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, stopped block, start handling, odd kinds
        queue_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);   // delay counter steps while stopped
        queue_pair(16'sd32767, -16'sd32768, 1'b0, 1'b1);   // dropped while stopped
        queue_req(2'd3);                                   // unused kind
        queue_req(pgf_pkg::REQ_STOP);                      // stop while stopped
        queue_req(pgf_pkg::REQ_START);
        queue_req(pgf_pkg::REQ_START);                     // start while running
        queue_pair(16'sd32767, -16'sd32768, 1'b0, 1'b0);   // gain still zero
        for (int i = 0; i < DELAY_BLOCKS; i++)
            queue_pair(pick_sample(), pick_sample(), 1'b1, i[0]);
        queue_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);   // first ramp step
        queue_pair(16'sd32767, 16'sd1, 1'b1, 1'b1);
        queue_req(pgf_pkg::REQ_STOP);
        queue_pair(-16'sd1, 16'sd1, 1'b0, 1'b0);           // dropped after stop
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(pgf_pkg::CFG_ENC_MODE, 16'(modes[ph]));
            write_reg(pgf_pkg::CFG_VOLUME_GAIN, vols[ph]);
            // field extremes under the new setting
            queue_req(pgf_pkg::REQ_START);
            queue_pair(16'sd32767, -16'sd32768, 1'b0, 1'b0);
            queue_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
            queue_pair(-16'sd32768, 16'sd5, 1'b0, 1'b1);
            sent = 4;
            while (sent < PHASE_ITEMS)
            begin
                calm = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_req(pgf_pkg::REQ_W'($urandom_range(0, 3)));
                    sent++;
                end
                else
                    sent += queue_session();
                while (pending_reqs.size() > 8)
                    @(posedge clk);
            end
            calm = 1'b0;
            drain();
        end

        if (fails == 0)
            $display("pcm_gain_fade_formatter: match");
        else
            $display("pcm_gain_fade_formatter: mismatch");
        $finish;
    end

    // run limit, many times the slowest correct run
    initial
    begin
        #5_000_000;
        $display("pcm_gain_fade_formatter: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pgf_pkg.sv
hw/rtl/pgf_front.sv
hw/rtl/pgf_queue.sv
hw/rtl/pgf_back.sv
hw/rtl/pcm_gain_fade_formatter.sv
dv/pcm_gain_fade_formatter_tb.sv
